### hw/rtl/rsg_pkg.sv
// Package for the sky gradient pixel core: widths, constants, register codes, stage bundles.
package rsg_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;

    // Register file
    localparam int CFG_DATA_W = COORD_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int MODE_W     = 2;
    localparam int FACT_W     = 10;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_R = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_G = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_B = 3'd5;

    localparam logic [MODE_W-1:0] MODE_GRAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SKY    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CUSTOM = 2'd2;

    // Fixed-point widths
    localparam int Q1_W     = FRAC_BITS + 1;          // u, v
    localparam int DIR_W    = FRAC_BITS + 4;          // signed direction
    localparam int ABS_W    = FRAC_BITS + 3;          // |x|
    localparam int AY_W     = FRAC_BITS + 2;          // |y|
    localparam int LEN2_W   = 2 * FRAC_BITS + 7;      // squared length
    localparam int SQ_STEPS = (LEN2_W + 1) / 2;       // one root bit per stage
    localparam int SQ_W     = LEN2_W + 1;
    localparam int LEN_W    = SQ_STEPS;
    localparam int ACC_W    = FRAC_BITS + 1 + FACT_W; // blend accumulator
    localparam int SCALE_W  = 24;
    localparam int PROD_W   = ACC_W + SCALE_W;
    localparam int CH_SHIFT = FRAC_BITS + 8 + 16;
    localparam int CH_W     = 8;

    localparam logic [SCALE_W-1:0] SCALE_Q16 = 24'd16776560;
    localparam int FIFTH_INT = ((2 ** (FRAC_BITS + 1)) + 9) / 10;
    localparam logic [Q1_W-1:0] FIFTH_Q = Q1_W'(FIFTH_INT);

    // Q2.8 colors
    localparam logic [FACT_W-1:0] F_ONE   = 10'd256;
    localparam logic [FACT_W-1:0] F_ZERO  = 10'd0;
    localparam logic [FACT_W-1:0] SKY_R   = 10'd128;
    localparam logic [FACT_W-1:0] SKY_G   = 10'd179;
    localparam logic [FACT_W-1:0] SKY_B   = 10'd256;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [COORD_BITS-1:0] width;
        logic [COORD_BITS-1:0] height;
        logic [FACT_W-1:0]     blend_r;
        logic [FACT_W-1:0]     blend_g;
        logic [FACT_W-1:0]     blend_b;
    } cfg_t;

    typedef struct packed {
        logic [Q1_W-1:0] u;
        logic [Q1_W-1:0] v;
    } uv_t;

    typedef struct packed {
        uv_t             uv;
        logic            yneg;
        logic [AY_W-1:0] ay;
    } side_t;

    typedef struct packed {
        side_t            side;
        logic [LEN_W-1:0] len;
    } len_t;

    typedef struct packed {
        uv_t                  uv;
        logic [FRAC_BITS-1:0] t;
    } shade_in_t;

endpackage

### hw/rtl/ray_sky_gradient_pixel_core.sv
// Top level of the sky gradient pixel core: registers, stall control and stage chain.
//
//  channel  direction  ports                               handshake
//  s_       in         s_column, s_row                     s_valid / s_ready
//  m_       out        m_red, m_green, m_blue              m_valid / m_ready
//  cfg_     in         cfg_index, cfg_wdata                cfg_wr_en, no wait
//
// One pixel per clock while the output is not stalled; the chain runs through the u/v
// dividers, the direction, squares and the 20-bit root, the unit-y divider and t, then
// blend and scaling. A stalled output holds every stage in place; no item is lost.
// Reset clears the valid bits and loads the register defaults.
module ray_sky_gradient_pixel_core import rsg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_column,
    input  logic [COORD_BITS-1:0] s_row,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CH_W-1:0]       m_red,
    output logic [CH_W-1:0]       m_green,
    output logic [CH_W-1:0]       m_blue,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t      cfg_reg;
    logic      adv;
    logic      u_valid, v_valid, len_valid, unit_valid;
    uv_t       uv;
    len_t      len_bus;
    shade_in_t shade_bus;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode    <= MODE_SKY;
            cfg_reg.width   <= COORD_BITS'(200);
            cfg_reg.height  <= COORD_BITS'(100);
            cfg_reg.blend_r <= SKY_R;
            cfg_reg.blend_g <= SKY_G;
            cfg_reg.blend_b <= SKY_B;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MODE:    cfg_reg.mode    <= cfg_wdata[MODE_W-1:0];
                REG_WIDTH:   cfg_reg.width   <= cfg_wdata[COORD_BITS-1:0];
                REG_HEIGHT:  cfg_reg.height  <= cfg_wdata[COORD_BITS-1:0];
                REG_BLEND_R: cfg_reg.blend_r <= cfg_wdata[FACT_W-1:0];
                REG_BLEND_G: cfg_reg.blend_g <= cfg_wdata[FACT_W-1:0];
                REG_BLEND_B: cfg_reg.blend_b <= cfg_wdata[FACT_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the whole pipe unless a finished item is held at the output
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    rsg_frac_div u_div_u (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(s_valid),
        .coord(s_column), .size(cfg_reg.width), .out_valid(u_valid), .frac(uv.u)
    );

    rsg_frac_div u_div_v (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(s_valid),
        .coord(s_row), .size(cfg_reg.height), .out_valid(v_valid), .frac(uv.v)
    );

    rsg_len u_len (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(u_valid && v_valid),
        .in_uv(uv), .out_valid(len_valid), .out_len(len_bus)
    );

    rsg_unit u_unit (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(len_valid),
        .in_len(len_bus), .out_valid(unit_valid), .out_shade(shade_bus)
    );

    rsg_shade u_shade (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(unit_valid),
        .in_shade(shade_bus), .cfg(cfg_reg), .out_valid(m_valid),
        .red(m_red), .green(m_green), .blue(m_blue)
    );

endmodule

### hw/rtl/rsg_frac_div.sv
// Pipelined restoring divider: coordinate over image size as unsigned Q1.F, saturated.
module rsg_frac_div import rsg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [COORD_BITS-1:0] coord,
    input  logic [COORD_BITS-1:0] size,
    output logic                  out_valid,
    output logic [Q1_W-1:0]       frac
);

    localparam int STEPS = Q1_W;

    logic                  vld_reg [STEPS];
    logic [COORD_BITS-1:0] rem_reg [STEPS];
    logic [COORD_BITS-1:0] div_reg [STEPS];
    logic [Q1_W-1:0]       quo_reg [STEPS];
    logic                  sat_reg [STEPS];

    logic [COORD_BITS-1:0] d_in;
    logic                  sat_in;
    logic [COORD_BITS-1:0] rem_src [STEPS];
    logic [COORD_BITS-1:0] div_src [STEPS];
    logic                  bit_src [STEPS];
    logic [COORD_BITS-1:0] rem_nx  [STEPS];
    logic                  qb_nx   [STEPS];
    logic [COORD_BITS:0]   trial   [STEPS];
    logic [COORD_BITS:0]   diff    [STEPS];

    // Treat zero size as one; flag quotients that overflow Q1.F
    assign d_in   = (size == '0) ? COORD_BITS'(1) : size;
    assign sat_in = ({1'b0, coord} >= {d_in, 1'b0});

    // One quotient bit per stage
    always_comb begin
        for (int s = 0; s < STEPS; s++) begin
            rem_src[s] = (s == 0) ? (coord >> 1) : rem_reg[(s == 0) ? 0 : s - 1];
            div_src[s] = (s == 0) ? d_in : div_reg[(s == 0) ? 0 : s - 1];
            bit_src[s] = (s == 0) ? coord[0] : 1'b0;
            trial[s]   = {rem_src[s], bit_src[s]};
            diff[s]    = trial[s] - {1'b0, div_src[s]};
            if (trial[s] >= {1'b0, div_src[s]}) begin
                qb_nx[s]  = 1'b1;
                rem_nx[s] = diff[s][COORD_BITS-1:0];
            end else begin
                qb_nx[s]  = 1'b0;
                rem_nx[s] = trial[s][COORD_BITS-1:0];
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < STEPS; s++) vld_reg[s] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < STEPS; s++) vld_reg[s] <= vld_reg[s-1];
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= rem_nx[0];
            div_reg[0] <= div_src[0];
            quo_reg[0] <= Q1_W'(qb_nx[0]);
            sat_reg[0] <= sat_in;
            for (int s = 1; s < STEPS; s++) begin
                rem_reg[s] <= rem_nx[s];
                div_reg[s] <= div_src[s];
                quo_reg[s] <= {quo_reg[s-1][Q1_W-2:0], qb_nx[s]};
                sat_reg[s] <= sat_reg[s-1];
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign frac      = sat_reg[STEPS-1] ? '1 : quo_reg[STEPS-1];

endmodule

### hw/rtl/rsg_len.sv
// Ray direction, squared length and pipelined integer square root.
module rsg_len import rsg_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic adv,
    input  logic in_valid,
    input  uv_t  in_uv,
    output logic out_valid,
    output len_t out_len
);

    localparam int NST = SQ_STEPS + 2;
    localparam logic [DIR_W-1:0]  TWO_Q  = DIR_W'(2 ** (FRAC_BITS + 1));
    localparam logic [DIR_W-1:0]  ONE_Q  = DIR_W'(2 ** FRAC_BITS);
    localparam logic [LEN2_W-1:0] ONE_SQ = LEN2_W'(1) << (2 * FRAC_BITS);

    logic                  vld_reg [NST];
    side_t                 side_reg [NST];
    logic [ABS_W-1:0]      ax_reg;
    logic [2*ABS_W-1:0]    ax2_reg;
    logic [2*AY_W-1:0]     ay2_reg;
    logic [SQ_W-1:0]       x_reg   [SQ_STEPS];
    logic [SQ_W-1:0]       res_reg [SQ_STEPS];

    logic signed [DIR_W-1:0] x_dir, y_dir;
    logic [DIR_W-1:0]        ax_full, ay_full;
    logic [LEN2_W-1:0]       len2;
    logic [SQ_W-1:0]         x_src   [SQ_STEPS];
    logic [SQ_W-1:0]         res_src [SQ_STEPS];
    logic [SQ_W-1:0]         x_nx    [SQ_STEPS];
    logic [SQ_W-1:0]         res_nx  [SQ_STEPS];
    logic [SQ_W-1:0]         probe   [SQ_STEPS];
    logic [SQ_W-1:0]         bitv    [SQ_STEPS];

    // Direction x = 4u - 2, y = 2v - 1 and their magnitudes
    always_comb begin
        x_dir   = $signed({1'b0, in_uv.u, 2'b00} - TWO_Q);
        y_dir   = $signed({2'b00, in_uv.v, 1'b0} - ONE_Q);
        ax_full = x_dir[DIR_W-1] ? DIR_W'(-x_dir) : DIR_W'(x_dir);
        ay_full = y_dir[DIR_W-1] ? DIR_W'(-y_dir) : DIR_W'(y_dir);
    end

    // Sum of squares plus z squared
    assign len2 = LEN2_W'(ax2_reg) + LEN2_W'(ay2_reg) + ONE_SQ;

    // One root bit per stage
    always_comb begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            x_src[k]   = (k == 0) ? SQ_W'(len2) : x_reg[(k == 0) ? 0 : k - 1];
            res_src[k] = (k == 0) ? '0 : res_reg[(k == 0) ? 0 : k - 1];
            bitv[k]    = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
            probe[k]   = res_src[k] + bitv[k];
            if (x_src[k] >= probe[k]) begin
                x_nx[k]   = x_src[k] - probe[k];
                res_nx[k] = (res_src[k] >> 1) + bitv[k];
            end else begin
                x_nx[k]   = x_src[k];
                res_nx[k] = res_src[k] >> 1;
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NST; s++) vld_reg[s] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < NST; s++) vld_reg[s] <= vld_reg[s-1];
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0].uv   <= in_uv;
            side_reg[0].yneg <= y_dir[DIR_W-1];
            side_reg[0].ay   <= ay_full[AY_W-1:0];
            ax_reg           <= ax_full[ABS_W-1:0];
            for (int s = 1; s < NST; s++) side_reg[s] <= side_reg[s-1];
            ax2_reg <= ax_reg * ax_reg;
            ay2_reg <= side_reg[0].ay * side_reg[0].ay;
            for (int k = 0; k < SQ_STEPS; k++) begin
                x_reg[k]   <= x_nx[k];
                res_reg[k] <= res_nx[k];
            end
        end
    end

    assign out_valid    = vld_reg[NST-1];
    assign out_len.side = side_reg[NST-1];
    assign out_len.len  = res_reg[SQ_STEPS-1][LEN_W-1:0];

endmodule

### hw/rtl/rsg_unit.sv
// Pipelined divider for the unit y component, then the blend parameter t.
module rsg_unit import rsg_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      adv,
    input  logic      in_valid,
    input  len_t      in_len,
    output logic      out_valid,
    output shade_in_t out_shade
);

    localparam int STEPS = FRAC_BITS;
    localparam int NST   = STEPS + 1;
    localparam logic [FRAC_BITS:0] ONE_T = (FRAC_BITS + 1)'(2 ** FRAC_BITS);

    logic                 vld_reg  [NST];
    side_t                side_reg [STEPS];
    logic [LEN_W-1:0]     rem_reg  [STEPS];
    logic [LEN_W-1:0]     div_reg  [STEPS];
    logic [FRAC_BITS-1:0] quo_reg  [STEPS];
    logic                 clamp_reg [STEPS];
    shade_in_t            out_reg;

    logic [LEN_W-1:0] rem_src [STEPS];
    logic [LEN_W-1:0] div_src [STEPS];
    logic [LEN_W:0]   trial   [STEPS];
    logic [LEN_W:0]   diff    [STEPS];
    logic [LEN_W-1:0] rem_nx  [STEPS];
    logic             qb_nx   [STEPS];
    logic             clamp_in;
    logic [FRAC_BITS-1:0] mag;
    logic [FRAC_BITS:0]   t_sum;

    // Ratio reaches one when |y| is not below the length
    assign clamp_in = (LEN_W'(in_len.side.ay) >= in_len.len);

    // One quotient bit per stage
    always_comb begin
        for (int s = 0; s < STEPS; s++) begin
            rem_src[s] = (s == 0) ? LEN_W'(in_len.side.ay) : rem_reg[(s == 0) ? 0 : s - 1];
            div_src[s] = (s == 0) ? in_len.len : div_reg[(s == 0) ? 0 : s - 1];
            trial[s]   = {rem_src[s], 1'b0};
            diff[s]    = trial[s] - {1'b0, div_src[s]};
            if (trial[s] >= {1'b0, div_src[s]}) begin
                qb_nx[s]  = 1'b1;
                rem_nx[s] = diff[s][LEN_W-1:0];
            end else begin
                qb_nx[s]  = 1'b0;
                rem_nx[s] = trial[s][LEN_W-1:0];
            end
        end
    end

    // Map the unit y component onto t in [0, 1)
    always_comb begin
        mag   = clamp_reg[STEPS-1] ? '1 : quo_reg[STEPS-1];
        t_sum = side_reg[STEPS-1].yneg ? (ONE_T - (FRAC_BITS + 1)'(mag))
                                        : (ONE_T + (FRAC_BITS + 1)'(mag));
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NST; s++) vld_reg[s] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < NST; s++) vld_reg[s] <= vld_reg[s-1];
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0]  <= in_len.side;
            rem_reg[0]   <= rem_nx[0];
            div_reg[0]   <= div_src[0];
            quo_reg[0]   <= FRAC_BITS'(qb_nx[0]);
            clamp_reg[0] <= clamp_in;
            for (int s = 1; s < STEPS; s++) begin
                side_reg[s]  <= side_reg[s-1];
                rem_reg[s]   <= rem_nx[s];
                div_reg[s]   <= div_src[s];
                quo_reg[s]   <= {quo_reg[s-1][FRAC_BITS-2:0], qb_nx[s]};
                clamp_reg[s] <= clamp_reg[s-1];
            end
            out_reg.uv <= side_reg[STEPS-1].uv;
            out_reg.t  <= t_sum[FRAC_BITS:1];
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_shade = out_reg;

endmodule

### hw/rtl/rsg_shade.sv
// Color blend per mode, scale by 255.99 and saturate to 8-bit channels.
module rsg_shade import rsg_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  shade_in_t       in_shade,
    input  cfg_t            cfg,
    output logic            out_valid,
    output logic [CH_W-1:0] red,
    output logic [CH_W-1:0] green,
    output logic [CH_W-1:0] blue
);

    localparam int NST   = 4;
    localparam int NCH   = 3;
    localparam int HI_W  = PROD_W - CH_SHIFT;
    localparam logic [Q1_W-1:0] ONE_T = Q1_W'(2 ** FRAC_BITS);

    logic              vld_reg [NST];
    logic [ACC_W-1:0]  p1_reg  [NCH];
    logic [ACC_W-1:0]  p2_reg  [NCH];
    logic [ACC_W-1:0]  acc_reg [NCH];
    logic [PROD_W-1:0] prod_reg [NCH];
    logic [CH_W-1:0]   ch_reg  [NCH];

    logic [FACT_W-1:0] fa [NCH];
    logic [FACT_W-1:0] fb [NCH];
    logic [Q1_W-1:0]   grad [NCH];
    logic [Q1_W-1:0]   omt;
    logic [ACC_W-1:0]  p1_nx [NCH];
    logic [ACC_W-1:0]  p2_nx [NCH];
    logic [HI_W-1:0]   hi [NCH];

    // Pick endpoint colors and products for the mode
    always_comb begin
        omt     = ONE_T - Q1_W'(in_shade.t);
        grad[0] = in_shade.uv.u;
        grad[1] = in_shade.uv.v;
        grad[2] = FIFTH_Q;
        fa[0] = F_ONE;  fa[1] = F_ONE;  fa[2] = F_ONE;
        fb[0] = SKY_R;  fb[1] = SKY_G;  fb[2] = SKY_B;
        if (cfg.mode == MODE_CUSTOM) begin
            fa[0] = F_ZERO;      fa[1] = F_ONE;       fa[2] = F_ZERO;
            fb[0] = cfg.blend_r; fb[1] = cfg.blend_g; fb[2] = cfg.blend_b;
        end
        for (int c = 0; c < NCH; c++) begin
            case (cfg.mode)
                MODE_GRAD: begin
                    p1_nx[c] = ACC_W'({grad[c], 8'h00});
                    p2_nx[c] = '0;
                end
                MODE_SKY, MODE_CUSTOM: begin
                    p1_nx[c] = ACC_W'(omt) * ACC_W'(fa[c]);
                    p2_nx[c] = ACC_W'(in_shade.t) * ACC_W'(fb[c]);
                end
                default: begin
                    p1_nx[c] = '0;
                    p2_nx[c] = '0;
                end
            endcase
            hi[c] = prod_reg[c][PROD_W-1:CH_SHIFT];
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NST; s++) vld_reg[s] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < NST; s++) vld_reg[s] <= vld_reg[s-1];
        end
    end

    // Multiply, accumulate, scale, saturate
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < NCH; c++) begin
                p1_reg[c]   <= p1_nx[c];
                p2_reg[c]   <= p2_nx[c];
                acc_reg[c]  <= p1_reg[c] + p2_reg[c];
                prod_reg[c] <= PROD_W'(acc_reg[c]) * PROD_W'(SCALE_Q16);
                ch_reg[c]   <= (hi[c] > HI_W'(8'hFF)) ? 8'hFF : hi[c][CH_W-1:0];
            end
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign red       = ch_reg[0];
    assign green     = ch_reg[1];
    assign blue      = ch_reg[2];

endmodule

### hw/rtl/rsg_checker.sv
// Port-level checker for the sky gradient pixel core, bound to the top level.
module rsg_checker import rsg_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [COORD_BITS-1:0] s_column,
    input logic [COORD_BITS-1:0] s_row,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [CH_W-1:0]       m_red,
    input logic [CH_W-1:0]       m_green,
    input logic [CH_W-1:0]       m_blue,
    input logic                  cfg_wr_en,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
                                && $stable(m_blue))
        else $error("stalled result changed");

    // Accept input whenever the output register is empty
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // Stop input while a result is held
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken during output stall");

    // Drop results across reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind ray_sky_gradient_pixel_core rsg_checker u_rsg_checker (.*);
